### hw/rtl/stepper_velocity_pid_planner_core_defines.svh
// Assertion macros shared by the planner RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef STEPPER_VELOCITY_PID_PLANNER_CORE_DEFINES_SVH
`define STEPPER_VELOCITY_PID_PLANNER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SVPP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SVPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/svpp_pkg.sv
package svpp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GAIN_P      = 3'd0;
  localparam logic [2:0] CFG_GAIN_I      = 3'd1;
  localparam logic [2:0] CFG_GAIN_D      = 3'd2;
  localparam logic [2:0] CFG_ACCEL_LIMIT = 3'd3;
  localparam logic [2:0] CFG_SPEED_LIMIT = 3'd4;
  localparam logic [2:0] CFG_MIN_SPEED   = 3'd5;
  localparam logic [2:0] CFG_UPDATE_MS   = 3'd6;

  // Result status codes.
  localparam logic [2:0] ST_APPLIED  = 3'd0;
  localparam logic [2:0] ST_TOO_SOON = 3'd1;
  localparam logic [2:0] ST_GAP_LONG = 3'd2;
  localparam logic [2:0] ST_TRIP     = 3'd3;
  localparam logic [2:0] ST_DECEL    = 3'd4;

  // Fixed controller constants.
  localparam int STEP_RATE_HZ    = 10000;
  localparam int VEL_DEAD_BAND   = 256;
  localparam int POS_DEAD_BAND   = 1;
  localparam int FLOOR_ACCEL     = 1000;
  localparam int FLOOR_MIN_SPEED = 256;
  localparam int MS_SCALE_Q8     = 256000;
  localparam int TRIP_LIMIT_Q8   = 25600000;
  localparam int PERIOD_NUM      = STEP_RATE_HZ * 256;

  // Datapath widths.
  localparam int DIVN_W = 44;
  localparam int DIVS_W = 32;
  localparam int QUO_W  = DIVN_W + 1;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  typedef struct packed {
    logic                     start;
    logic signed [DIVN_W-1:0] dividend;
    logic        [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/svpp_mul.sv
module svpp_mul (
  input  logic                                 clk,
  input  logic signed [svpp_pkg::MUL_W-1:0]    op_a,
  input  logic signed [svpp_pkg::MUL_W-1:0]    op_b,
  output logic signed [svpp_pkg::PROD_W-1:0]   prod
);
  import svpp_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  // Registered signed multiply, one result per cycle.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

### hw/rtl/svpp_div.sv
module svpp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  svpp_pkg::div_req_t  req,
  output svpp_pkg::div_rsp_t  rsp
);
  import svpp_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [5:0]        cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVN_W-1:0] work_r;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W+1:0] diff;
  logic [DIVN_W-1:0] mag;

  // Magnitude of the signed dividend.
  assign mag = req.dividend[DIVN_W-1] ? DIVN_W'(-req.dividend) : DIVN_W'(req.dividend);

  // One restoring step: shift in the next dividend bit, try the subtract.
  assign rem_sh = {rem_r, work_r[DIVN_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  // Control with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIVN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and shifting dividend/quotient word.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      dvs_r  <= req.divisor;
      work_r <= mag;
      neg_r  <= req.dividend[DIVN_W-1];
    end else if (busy_r) begin
      if (!diff[DIVS_W+1]) begin
        rem_r  <= diff[DIVS_W-1:0];
        work_r <= {work_r[DIVN_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[DIVS_W-1:0];
        work_r <= {work_r[DIVN_W-2:0], 1'b0};
      end
    end
  end

  // Quotient truncates toward zero.
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed({1'b0, work_r}) : $signed({1'b0, work_r});

endmodule

### hw/rtl/stepper_velocity_pid_planner_core.sv
// Velocity PID planner for up to JOINTS stepper joints. Each input word is one
// update for one joint; each produces exactly one result word. The block
// takes one update at a time: in_stall is high from acceptance until the
// result is loaded into the output register, so a waiting result does not
// block the next update. An update that is skipped (too soon, gap too long,
// joint out of range, inactive joint in emergency) goes from the check state
// straight to the finish state. Normal updates and emergency brake steps use a
// shared restoring divider (position change over dt, acceleration limit over
// dt, step rate over speed) and a shared registered 33x33 multiplier used once
// per term. Configuration writes are always ready.
module stepper_velocity_pid_planner_core #(
  parameter int JOINTS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_joint,
  input  logic [15:0]        in_elapsed_ms,
  input  logic signed [23:0] in_target_pos,
  input  logic signed [31:0] in_target_vel,
  input  logic signed [23:0] in_measured_pos,
  input  logic               in_enabled,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_step_period,
  output logic               out_direction,
  output logic               out_joint_active,
  output logic               out_drive_enable,
  output logic signed [31:0] out_measured_vel,
  output logic               out_emergency,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import svpp_pkg::*;

  `include "stepper_velocity_pid_planner_core_defines.svh"

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_MMV  = 5'd2;
  localparam logic [4:0] S_MDIV = 5'd3;
  localparam logic [4:0] S_ERR  = 5'd4;
  localparam logic [4:0] S_PM   = 5'd5;
  localparam logic [4:0] S_TP   = 5'd6;
  localparam logic [4:0] S_TI   = 5'd7;
  localparam logic [4:0] S_TD   = 5'd8;
  localparam logic [4:0] S_SUM  = 5'd9;
  localparam logic [4:0] S_LIMM = 5'd10;
  localparam logic [4:0] S_LIMD = 5'd11;
  localparam logic [4:0] S_VEL  = 5'd12;
  localparam logic [4:0] S_CLMP = 5'd13;
  localparam logic [4:0] S_MINS = 5'd14;
  localparam logic [4:0] S_PST  = 5'd15;
  localparam logic [4:0] S_PDIV = 5'd16;
  localparam logic [4:0] S_EACC = 5'd17;
  localparam logic [4:0] S_EDIV = 5'd18;
  localparam logic [4:0] S_EMIN = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;

  // Configuration registers.
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [19:0]        accel_limit_r;
  logic [30:0]        speed_limit_r;
  logic [30:0]        min_speed_r;
  logic [15:0]        update_ms_r;

  // Per-joint state.
  logic signed [23:0] last_pos_r [JOINTS];
  logic signed [31:0] verr_r     [JOINTS];
  logic signed [31:0] svel_r     [JOINTS];
  logic [JOINTS-1:0]  act_r;
  logic               emerg_r;

  // Control.
  logic [4:0] state_r, state_nxt;
  logic       out_valid_r;
  logic       fin_go;

  // Working registers for the update in flight.
  logic [JW-1:0]      j_r;
  logic               oor_r;
  logic               meas_r;
  logic [15:0]        dt_r;
  logic signed [23:0] tpos_r, mpos_r, lastp_r;
  logic signed [31:0] tvel_r, perr_r;
  logic               en_r;
  logic signed [31:0] v_r;
  logic               actw_r;
  logic signed [31:0] mvel_r, ev_r, dvel_r;
  logic signed [24:0] ep_r;
  logic signed [51:0] acc_r;
  logic               trip_r;
  logic signed [40:0] adjc_r;
  logic signed [41:0] vsum_r;
  logic [2:0]         status_r;
  logic [31:0]        tps_r;

  // Output register.
  logic [2:0]         o_status_r;
  logic [31:0]        o_tps_r;
  logic               o_dir_r, o_act_r, o_drv_r, o_emerg_r;
  logic signed [31:0] o_mvel_r;

  // Shared units.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t                 dreq;
  div_rsp_t                 drsp;

  // Helpers.
  logic [15:0]        per;
  logic [16:0]        per2;
  logic               in_rng;
  logic [JW-1:0]      in_idx;
  logic [19:0]        acc_eff;
  logic [30:0]        mins_eff;
  logic signed [24:0] delta;
  logic signed [32:0] ev_wide;
  logic signed [32:0] dv_wide;
  logic signed [24:0] ep_wide;
  logic [32:0]        ev_abs;
  logic [24:0]        ep_abs;
  logic [32:0]        v_abs;
  logic signed [49:0] term;
  logic signed [51:0] term_x;
  logic signed [51:0] lim_x;
  logic signed [41:0] spd_x;
  logic [39:0]        eadj;

  function automatic logic signed [31:0] sat32(input logic signed [QUO_W-1:0] x);
    logic signed [QUO_W-1:0] hi;
    logic signed [QUO_W-1:0] lo;
    hi = QUO_W'(32'sh7FFFFFFF);
    lo = -QUO_W'(33'sh080000000);
    if (x > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  svpp_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  svpp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Derived limits and simple arithmetic.
  assign per      = (update_ms_r == 16'd0) ? 16'd1 : update_ms_r;
  assign per2     = {per, 1'b0};
  assign in_rng   = 32'(in_joint) < JOINTS;
  assign in_idx   = JW'(in_joint);
  assign acc_eff  = (accel_limit_r > 20'(FLOOR_ACCEL)) ? accel_limit_r : 20'(FLOOR_ACCEL);
  assign mins_eff = (min_speed_r > 31'(FLOOR_MIN_SPEED)) ? min_speed_r : 31'(FLOOR_MIN_SPEED);
  assign delta    = 25'(mpos_r) - 25'(lastp_r);
  assign ev_wide  = 33'(tvel_r) - 33'(mvel_r);
  assign ev_abs   = ev_wide[32] ? 33'(-ev_wide) : 33'(ev_wide);
  assign ep_wide  = 25'(tpos_r) - 25'(mpos_r);
  assign ep_abs   = ep_wide[24] ? 25'(-ep_wide) : 25'(ep_wide);
  assign dv_wide  = 33'(ev_r) - 33'(perr_r);
  assign v_abs    = v_r[31] ? 33'(-33'(v_r)) : 33'(v_r);
  assign term     = (state_r == S_TI) ? $signed(prod[57:8]) : $signed(prod[65:16]);
  assign term_x   = 52'(term);
  assign lim_x    = 52'(drsp.quotient);
  assign spd_x    = $signed({11'b0, speed_limit_r});
  assign eadj     = drsp.quotient[39:0];

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CHK: begin
        mul_a = emerg_r ? $signed({13'b0, acc_eff}) : 33'(delta);
        mul_b = 33'(MS_SCALE_Q8);
      end
      S_PM: begin
        mul_a = 33'(gain_p_r);
        mul_b = 33'(ev_r);
      end
      S_TP: begin
        mul_a = 33'(gain_i_r);
        mul_b = 33'(ep_r);
      end
      S_TI: begin
        mul_a = 33'(gain_d_r);
        mul_b = 33'(dvel_r);
      end
      S_SUM: begin
        mul_a = $signed({13'b0, accel_limit_r});
        mul_b = 33'(MS_SCALE_Q8);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider request.
  always_comb begin
    dreq.start    = (state_r == S_MMV) || (state_r == S_LIMM) || (state_r == S_EACC) ||
                    ((state_r == S_PST) && (v_r != 32'sd0));
    dreq.dividend = (state_r == S_PST) ? DIVN_W'(PERIOD_NUM) : $signed(prod[DIVN_W-1:0]);
    dreq.divisor  = (state_r == S_PST) ? v_abs[31:0] : {16'b0, dt_r};
  end

  assign fin_go = !out_valid_r || !out_stall;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CHK;
      S_CHK: begin
        if (oor_r || (dt_r < per)) begin
          state_nxt = S_FIN;
        end else if (emerg_r) begin
          state_nxt = actw_r ? S_EACC : S_FIN;
        end else if (17'(dt_r) > per2) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MMV;
        end
      end
      S_MMV:  state_nxt = S_MDIV;
      S_MDIV: if (drsp.done) state_nxt = S_ERR;
      S_ERR: begin
        if ((ev_abs > 33'(VEL_DEAD_BAND)) || (ep_abs > 25'(POS_DEAD_BAND))) begin
          state_nxt = S_PM;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PM:   state_nxt = S_TP;
      S_TP:   state_nxt = S_TI;
      S_TI:   state_nxt = S_TD;
      S_TD:   state_nxt = S_SUM;
      S_SUM:  state_nxt = trip_r ? S_FIN : S_LIMM;
      S_LIMM: state_nxt = S_LIMD;
      S_LIMD: if (drsp.done) state_nxt = S_VEL;
      S_VEL:  state_nxt = S_CLMP;
      S_CLMP: state_nxt = S_MINS;
      S_MINS: state_nxt = S_PST;
      S_PST:  state_nxt = (v_r == 32'sd0) ? S_FIN : S_PDIV;
      S_PDIV: if (drsp.done) state_nxt = S_FIN;
      S_EACC: state_nxt = S_EDIV;
      S_EDIV: if (drsp.done) state_nxt = S_EMIN;
      S_EMIN: state_nxt = (v_abs < 33'(mins_eff)) ? S_FIN : S_PST;
      S_FIN:  if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and per-joint store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      emerg_r       <= 1'b0;
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      accel_limit_r <= '0;
      speed_limit_r <= '0;
      min_speed_r   <= 31'd256;
      update_ms_r   <= 16'd10;
      act_r         <= '0;
      for (int i = 0; i < JOINTS; i++) begin
        last_pos_r[i] <= '0;
        verr_r[i]     <= '0;
        svel_r[i]     <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GAIN_P:      gain_p_r      <= cfg_data;
          CFG_GAIN_I:      gain_i_r      <= cfg_data;
          CFG_GAIN_D:      gain_d_r      <= cfg_data;
          CFG_ACCEL_LIMIT: accel_limit_r <= cfg_data[19:0];
          CFG_SPEED_LIMIT: speed_limit_r <= cfg_data[30:0];
          CFG_MIN_SPEED:   min_speed_r   <= cfg_data[30:0];
          CFG_UPDATE_MS:   update_ms_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if ((state_r == S_SUM) && trip_r) begin
        emerg_r <= 1'b1;
      end
      if ((state_r == S_FIN) && fin_go) begin
        out_valid_r <= 1'b1;
        if (!oor_r) begin
          svel_r[j_r] <= v_r;
          act_r[j_r]  <= actw_r;
          if (meas_r) begin
            last_pos_r[j_r] <= mpos_r;
            verr_r[j_r]     <= ev_r;
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working datapath.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        j_r      <= in_idx;
        oor_r    <= !in_rng;
        dt_r     <= in_elapsed_ms;
        tpos_r   <= in_target_pos;
        tvel_r   <= in_target_vel;
        mpos_r   <= in_measured_pos;
        en_r     <= in_enabled;
        meas_r   <= 1'b0;
        mvel_r   <= '0;
        tps_r    <= '0;
        trip_r   <= 1'b0;
        lastp_r  <= in_rng ? last_pos_r[in_idx] : '0;
        perr_r   <= in_rng ? verr_r[in_idx] : '0;
        v_r      <= in_rng ? svel_r[in_idx] : '0;
        actw_r   <= in_rng ? act_r[in_idx] : 1'b0;
        status_r <= ST_TOO_SOON;
      end
      S_CHK: begin
        if (oor_r || (dt_r < per)) begin
          status_r <= ST_TOO_SOON;
        end else if (emerg_r) begin
          status_r <= ST_DECEL;
        end else if (17'(dt_r) > per2) begin
          status_r <= ST_GAP_LONG;
        end else begin
          status_r <= ST_APPLIED;
          meas_r   <= 1'b1;
        end
      end
      S_MDIV: if (drsp.done) mvel_r <= sat32(drsp.quotient);
      S_ERR: begin
        ev_r   <= sat32(QUO_W'(ev_wide));
        ep_r   <= ep_wide;
        actw_r <= (ev_abs > 33'(VEL_DEAD_BAND)) || (ep_abs > 25'(POS_DEAD_BAND));
      end
      S_PM: dvel_r <= sat32(QUO_W'(dv_wide));
      S_TP: begin
        acc_r  <= term_x;
        trip_r <= term_x > 52'(TRIP_LIMIT_Q8);
      end
      S_TI, S_TD: begin
        acc_r  <= acc_r + term_x;
        trip_r <= trip_r || (term_x > 52'(TRIP_LIMIT_Q8));
      end
      S_SUM: if (trip_r) status_r <= ST_TRIP;
      S_LIMD: begin
        if (acc_r > lim_x) begin
          adjc_r <= 41'(lim_x);
        end else if (acc_r < -lim_x) begin
          adjc_r <= 41'(-lim_x);
        end else begin
          adjc_r <= 41'(acc_r);
        end
      end
      S_VEL: vsum_r <= 42'(v_r) + 42'(adjc_r);
      S_CLMP: begin
        if (vsum_r > spd_x) begin
          v_r <= 32'(spd_x);
        end else if (vsum_r < -spd_x) begin
          v_r <= 32'(-spd_x);
        end else begin
          v_r <= 32'(vsum_r);
        end
      end
      S_MINS: begin
        if (v_abs < 33'(min_speed_r)) begin
          v_r <= (v_r > 32'sd0) ? $signed({1'b0, min_speed_r}) : -$signed({1'b0, min_speed_r});
        end
      end
      S_PST: if (v_r == 32'sd0) tps_r <= 32'hFFFFFFFF;
      S_PDIV: if (drsp.done) tps_r <= drsp.quotient[31:0];
      S_EDIV: begin
        if (drsp.done) begin
          if (41'(eadj) > 41'(v_abs)) begin
            v_r <= '0;
          end else if (v_r > 32'sd0) begin
            v_r <= 32'(33'(v_r) - 33'(eadj));
          end else begin
            v_r <= 32'(33'(v_r) + 33'(eadj));
          end
        end
      end
      S_EMIN: if (v_abs < 33'(mins_eff)) actw_r <= 1'b0;
      S_FIN: begin
        if (fin_go) begin
          o_status_r <= status_r;
          o_tps_r    <= tps_r;
          o_dir_r    <= !oor_r && (v_r > 32'sd0);
          o_act_r    <= !oor_r && actw_r;
          o_drv_r    <= !oor_r && actw_r && en_r;
          o_mvel_r   <= ((status_r == ST_APPLIED) || (status_r == ST_TRIP)) ? mvel_r : '0;
          o_emerg_r  <= emerg_r;
        end
      end
      default: ;
    endcase
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_step_period  = o_tps_r;
  assign out_direction    = o_dir_r;
  assign out_joint_active = o_act_r;
  assign out_drive_enable = o_drv_r;
  assign out_measured_vel = o_mvel_r;
  assign out_emergency    = o_emerg_r;

  // The divider only finishes while the sequencer waits for it.
  `SVPP_ASSERT_IMPL(a_div_done_wait, drsp.done, (state_r == S_MDIV) || (state_r == S_LIMD) || (state_r == S_EDIV) || (state_r == S_PDIV), "divider finished outside a wait state")
  // A blocked output holds the finished update in place.
  `SVPP_ASSERT_NEXT(a_fin_hold, (state_r == S_FIN) && out_valid_r && out_stall, state_r == S_FIN, "result overwrote a waiting word")
  // The emergency flag is sticky.
  `SVPP_ASSERT_NEXT(a_emerg_sticky, emerg_r, emerg_r, "emergency flag cleared")
  // A trip result always reports the emergency flag.
  `SVPP_ASSERT_IMPL(a_trip_flag, out_valid_r && (out_status == ST_TRIP), out_emergency, "trip without emergency flag")

endmodule
